// ----- hw/rtl/pscr_pkg.sv -----
// Package for the PID stepper rate controller: widths, fixed constants,
// register indexes and register reset values.
// Depends on nothing; pid_stepper_rate_control imports it.
`timescale 1ns / 1ps

package pscr_pkg;

   // Fixed arithmetic constants of the controller.
   localparam int unsigned FREQ_CONSTANT  = 1000000;
   localparam int unsigned GAIN_FRAC_BITS = 16;

   // Field widths.
   localparam int unsigned FORCE_W  = 16;
   localparam int unsigned GAIN_W   = 24;
   localparam int unsigned SUM_W    = 32;
   localparam int unsigned SPEED_W  = 16;
   localparam int unsigned PERIOD_W = 16;
   localparam int unsigned DRIVE_W  = 32;
   localparam int unsigned LIMIT_W  = 15;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 24;

   // Product accumulator: gain times the widest operand, plus a sign bit.
   localparam int unsigned ACC_W = GAIN_W + SUM_W + 1;
   // Quotient of the accumulator by 2^GAIN_FRAC_BITS.
   localparam int unsigned QUO_W = ACC_W - GAIN_FRAC_BITS;

   // Dividend width for the step period division, at least one bit wider
   // than the period so that saturation can be seen.
   localparam int unsigned FREQ_BITS = $clog2(longint'(FREQ_CONSTANT) + 1);
   localparam int unsigned DVD_W = (FREQ_BITS > PERIOD_W + 1) ? FREQ_BITS : PERIOD_W + 1;

   localparam int unsigned CNT_W = 6;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_SETPOINT    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_KP          = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KI          = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_KD          = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SEP_LIMIT   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_FLOOR = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_CEIL  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_PID_ENABLE  = 3'd7;

   // Register reset values.
   localparam logic [FORCE_W-1:0]  RST_SETPOINT    = 16'd400;
   localparam logic [GAIN_W-1:0]   RST_KP          = 24'd524288;
   localparam logic [GAIN_W-1:0]   RST_KI          = 24'd197;
   localparam logic [GAIN_W-1:0]   RST_KD          = 24'd327680;
   localparam logic [LIMIT_W-1:0]  RST_SEP_LIMIT   = 15'd150;
   localparam logic [SPEED_W-1:0]  RST_SPEED_FLOOR = 16'd16;
   localparam logic [SPEED_W-1:0]  RST_SPEED_CEIL  = 16'd2000;
   localparam logic [PERIOD_W-1:0] RST_PERIOD      = 16'd500;

endpackage

// ----- hw/rtl/pid_stepper_rate_control.sv -----
// PID force-to-step-rate controller with integral separation, top level.
// Holds the registers, a bit-serial multiply-accumulate and a restoring
// divider. Depends on pscr_pkg.
`timescale 1ns / 1ps

// Usage
// Each force sample arrives as one word on the req_ channel (valid/ready) and
// produces exactly one result word on the rsp_ channel (valid/ready): the
// drive value, the motor direction, the step half-period and a flag that says
// whether the period was updated (pid_enable set).
// Registers are written through the csr_ port, one per cycle when csr_we is
// high; writes to them are expected only while no sample is in flight.
// Sequence: the accepting cycle forms the error and updates the integral, then
// comes a bit-serial multiply-accumulate (one bit of each of the three gains
// per cycle), a step that scales and saturates the drive and, when enabled,
// a clamp step and a restoring division of the frequency constant by the
// speed (one quotient bit per cycle). A last step loads the output register,
// waiting while a previous result is still held there unread, and returns
// the block to idle; only then does ready rise again, so a new sample is not
// taken before the previous one has been worked through.
// The output register parts the two sides: a new sample is taken while the
// previous result still waits, and a stalled receiver only holds the block
// back when the next result is ready to be loaded.
// Synchronous reset restores the configuration registers to their defaults,
// clears the integral and previous error, and sets the held period to 500.

module pid_stepper_rate_control
   import pscr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [FORCE_W-1:0]    req_measured_force,

   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_drive_valid,
   output logic                  rsp_direction,
   output logic [PERIOD_W-1:0]   rsp_half_period,
   output logic [DRIVE_W-1:0]    rsp_drive_value,

   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ROUND,
      ST_CLAMP,
      ST_DIV,
      ST_DONE
   } state_type;

   // Configuration registers.
   logic [FORCE_W-1:0]  setpoint_ff;
   logic [GAIN_W-1:0]   kp_ff, ki_ff, kd_ff;
   logic [LIMIT_W-1:0]  sep_limit_ff;
   logic [SPEED_W-1:0]  speed_floor_ff, speed_ceil_ff;
   logic                pid_enable_ff;

   // Controller state.
   state_type           state_ff, state_in;
   logic [FORCE_W-1:0]  prev_err_ff, prev_err_in;
   logic [SUM_W-1:0]    err_sum_ff, err_sum_in;
   logic [PERIOD_W-1:0] period_ff, period_in;

   // Datapath registers.
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [ACC_W-1:0]    mc_p_ff, mc_p_in;
   logic [ACC_W-1:0]    mc_i_ff, mc_i_in;
   logic [ACC_W-1:0]    mc_d_ff, mc_d_in;
   logic [GAIN_W-1:0]   gp_ff, gp_in, gi_ff, gi_in, gd_ff, gd_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [DRIVE_W-1:0]  drive_ff, drive_in;
   logic                dir_ff, dir_in;
   logic                upd_ff, upd_in;
   logic [SPEED_W-1:0]  speed_ff, speed_in;
   logic [SPEED_W-1:0]  rem_ff, rem_in;
   logic [DVD_W-1:0]    dvd_ff, dvd_in;

   // Output register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_upd_ff, rsp_upd_in;
   logic                rsp_dir_ff, rsp_dir_in;
   logic [PERIOD_W-1:0] rsp_period_ff, rsp_period_in;
   logic [DRIVE_W-1:0]  rsp_drive_ff, rsp_drive_in;

   // Combinational temporaries.
   logic [FORCE_W-1:0]  err;
   logic [FORCE_W-1:0]  err_mag;
   logic                use_int;
   logic [SUM_W:0]      sum_wide;
   logic [SUM_W-1:0]    sum_sat;
   logic [FORCE_W:0]    diff;
   logic [QUO_W-1:0]    quo;
   logic                acc_neg;
   logic [DRIVE_W:0]    drive_mag;
   logic [SPEED_W-1:0]  speed_hi;
   logic [SPEED_W-1:0]  speed_lo;
   logic [SPEED_W:0]    rem_shift;
   logic [SPEED_W:0]    trial;
   logic                q_bit;

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_drive_valid = rsp_upd_ff;
   assign rsp_direction   = rsp_dir_ff;
   assign rsp_half_period = rsp_period_ff;
   assign rsp_drive_value = rsp_drive_ff;

   always_comb begin
      state_in      = state_ff;
      prev_err_in   = prev_err_ff;
      err_sum_in    = err_sum_ff;
      period_in     = period_ff;
      acc_in        = acc_ff;
      mc_p_in       = mc_p_ff;
      mc_i_in       = mc_i_ff;
      mc_d_in       = mc_d_ff;
      gp_in         = gp_ff;
      gi_in         = gi_ff;
      gd_in         = gd_ff;
      cnt_in        = cnt_ff;
      drive_in      = drive_ff;
      dir_in        = dir_ff;
      upd_in        = upd_ff;
      speed_in      = speed_ff;
      rem_in        = rem_ff;
      dvd_in        = dvd_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_upd_in    = rsp_upd_ff;
      rsp_dir_in    = rsp_dir_ff;
      rsp_period_in = rsp_period_ff;
      rsp_drive_in  = rsp_drive_ff;

      // Error, wrapped to 16 bits, and the integral separation test. The most
      // negative error has a magnitude of 0x8000, above any 15-bit limit.
      err      = setpoint_ff - req_measured_force;
      err_mag  = err[FORCE_W-1] ? (FORCE_W'(0) - err) : err;
      use_int  = (err_mag <= {1'b0, sep_limit_ff});
      sum_wide = {err_sum_ff[SUM_W-1], err_sum_ff}
               + {{(SUM_W+1-FORCE_W){err[FORCE_W-1]}}, err};
      if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
         sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
         sum_sat = sum_wide[SUM_W-1:0];
      end
      diff = {err[FORCE_W-1], err} - {prev_err_ff[FORCE_W-1], prev_err_ff};

      // Drive scaling with truncation toward zero.
      acc_neg = acc_ff[ACC_W-1];
      quo     = acc_ff[ACC_W-1:GAIN_FRAC_BITS]
              + QUO_W'(acc_neg & (|acc_ff[GAIN_FRAC_BITS-1:0]));

      drive_mag = drive_ff[DRIVE_W-1] ? ((DRIVE_W+1)'(0) - {1'b1, drive_ff})
                                      : {1'b0, drive_ff};
      speed_hi  = (drive_mag > {{(DRIVE_W+1-SPEED_W){1'b0}}, speed_ceil_ff})
                ? speed_ceil_ff : drive_mag[SPEED_W-1:0];
      speed_lo  = (speed_floor_ff == '0) ? SPEED_W'(1) : speed_floor_ff;

      rem_shift = {rem_ff, dvd_ff[DVD_W-1]};
      trial     = rem_shift - {1'b0, speed_ff};
      q_bit     = ~trial[SPEED_W];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (use_int) begin
                  err_sum_in = sum_sat;
               end
               prev_err_in = err;
               mc_p_in = {{(ACC_W-FORCE_W){err[FORCE_W-1]}}, err};
               mc_i_in = use_int ? {{(ACC_W-SUM_W){sum_sat[SUM_W-1]}}, sum_sat} : '0;
               mc_d_in = {{(ACC_W-FORCE_W-1){diff[FORCE_W]}}, diff};
               gp_in   = kp_ff;
               gi_in   = ki_ff;
               gd_in   = kd_ff;
               acc_in  = '0;
               cnt_in  = '0;
               state_in = ST_MUL;
            end
         end

         ST_MUL: begin
            // One bit of each gain per cycle, the three partial products summed.
            acc_in = acc_ff + (gp_ff[0] ? mc_p_ff : '0)
                            + (gi_ff[0] ? mc_i_ff : '0)
                            + (gd_ff[0] ? mc_d_ff : '0);
            mc_p_in = {mc_p_ff[ACC_W-2:0], 1'b0};
            mc_i_in = {mc_i_ff[ACC_W-2:0], 1'b0};
            mc_d_in = {mc_d_ff[ACC_W-2:0], 1'b0};
            gp_in   = {1'b0, gp_ff[GAIN_W-1:1]};
            gi_in   = {1'b0, gi_ff[GAIN_W-1:1]};
            gd_in   = {1'b0, gd_ff[GAIN_W-1:1]};
            cnt_in  = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(GAIN_W - 1)) begin
               state_in = ST_ROUND;
            end
         end

         ST_ROUND: begin
            dir_in = ~acc_neg;
            if (quo[QUO_W-1:DRIVE_W-1] != {(QUO_W-DRIVE_W+1){quo[QUO_W-1]}}) begin
               drive_in = quo[QUO_W-1] ? {1'b1, {(DRIVE_W-1){1'b0}}}
                                       : {1'b0, {(DRIVE_W-1){1'b1}}};
            end else begin
               drive_in = quo[DRIVE_W-1:0];
            end
            upd_in   = pid_enable_ff;
            state_in = pid_enable_ff ? ST_CLAMP : ST_DONE;
         end

         ST_CLAMP: begin
            // Max clamp first, min clamp last, so the minimum wins if crossed.
            speed_in = (speed_hi < speed_lo) ? speed_lo : speed_hi;
            rem_in   = '0;
            dvd_in   = DVD_W'(FREQ_CONSTANT);
            cnt_in   = '0;
            state_in = ST_DIV;
         end

         ST_DIV: begin
            // Restoring division; quotient bits shift in behind the dividend.
            rem_in = q_bit ? trial[SPEED_W-1:0] : rem_shift[SPEED_W-1:0];
            dvd_in = {dvd_ff[DVD_W-2:0], q_bit};
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DVD_W - 1)) begin
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               if (upd_ff) begin
                  period_in = (|dvd_ff[DVD_W-1:PERIOD_W]) ? {PERIOD_W{1'b1}}
                                                          : dvd_ff[PERIOD_W-1:0];
               end
               rsp_valid_in  = 1'b1;
               rsp_upd_in    = upd_ff;
               rsp_dir_in    = dir_ff;
               rsp_drive_in  = drive_ff;
               rsp_period_in = period_in;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff    <= RST_SETPOINT;
         kp_ff          <= RST_KP;
         ki_ff          <= RST_KI;
         kd_ff          <= RST_KD;
         sep_limit_ff   <= RST_SEP_LIMIT;
         speed_floor_ff <= RST_SPEED_FLOOR;
         speed_ceil_ff  <= RST_SPEED_CEIL;
         pid_enable_ff  <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_SETPOINT:    setpoint_ff    <= csr_wdata[FORCE_W-1:0];
            REG_KP:          kp_ff          <= csr_wdata[GAIN_W-1:0];
            REG_KI:          ki_ff          <= csr_wdata[GAIN_W-1:0];
            REG_KD:          kd_ff          <= csr_wdata[GAIN_W-1:0];
            REG_SEP_LIMIT:   sep_limit_ff   <= csr_wdata[LIMIT_W-1:0];
            REG_SPEED_FLOOR: speed_floor_ff <= csr_wdata[SPEED_W-1:0];
            REG_SPEED_CEIL:  speed_ceil_ff  <= csr_wdata[SPEED_W-1:0];
            REG_PID_ENABLE:  pid_enable_ff  <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         prev_err_ff   <= '0;
         err_sum_ff    <= '0;
         period_ff     <= RST_PERIOD;
         rsp_valid_ff  <= 1'b0;
         rsp_upd_ff    <= 1'b0;
         rsp_dir_ff    <= 1'b0;
         rsp_period_ff <= '0;
         rsp_drive_ff  <= '0;
      end else begin
         state_ff      <= state_in;
         prev_err_ff   <= prev_err_in;
         err_sum_ff    <= err_sum_in;
         period_ff     <= period_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_upd_ff    <= rsp_upd_in;
         rsp_dir_ff    <= rsp_dir_in;
         rsp_period_ff <= rsp_period_in;
         rsp_drive_ff  <= rsp_drive_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      acc_ff        <= acc_in;
      mc_p_ff       <= mc_p_in;
      mc_i_ff       <= mc_i_in;
      mc_d_ff       <= mc_d_in;
      gp_ff         <= gp_in;
      gi_ff         <= gi_in;
      gd_ff         <= gd_in;
      cnt_ff        <= cnt_in;
      drive_ff      <= drive_in;
      dir_ff        <= dir_in;
      upd_ff        <= upd_in;
      speed_ff      <= speed_in;
      rem_ff        <= rem_in;
      dvd_ff        <= dvd_in;
   end

endmodule

// ----- sim/tb.sv -----
// Testbench for pid_stepper_rate_control: a self-checking run that predicts every
// result word from its own copy of the controller state and compares them field by field.
// Depends on pscr_pkg and the pid_stepper_rate_control RTL; needs nothing else.
`timescale 1ns / 1ps

module tb
   import pscr_pkg::*;
();

   // Step clock and gain scaling of the controller, kept here as the testbench's own
   // copy so that a wrong value in the RTL package shows up as a mismatch.
   localparam longint STEP_CLOCK_HZ = 1000000;
   localparam int     GAIN_SHIFT    = 16;
   localparam int     CYCLE_LIMIT   = 300000;
   localparam int     RSP_HOLD_LEN  = 300;

   // One result word as the block presents it.
   typedef struct {
      bit                  drive_valid;
      bit                  direction;
      logic [PERIOD_W-1:0] half_period;
      logic [DRIVE_W-1:0]  drive_value;
   } drive_result_type;

   // Tracks the controller: shadow registers, loop state, and the drive results
   // still owed by the block, oldest first.
   class drive_tracker_type;
      logic signed [FORCE_W-1:0] setpoint;
      logic [GAIN_W-1:0]         kp, ki, kd;
      logic [LIMIT_W-1:0]        sep_limit;
      logic [SPEED_W-1:0]        speed_floor, speed_ceil;
      bit                        pid_enable;
      logic signed [FORCE_W-1:0] prev_err;
      logic signed [SUM_W-1:0]   err_sum;
      logic [PERIOD_W-1:0]       held_period;
      drive_result_type          pending_drives[$];
      int                        mismatches;

      function new();
         setpoint    = RST_SETPOINT;
         kp          = RST_KP;
         ki          = RST_KI;
         kd          = RST_KD;
         sep_limit   = RST_SEP_LIMIT;
         speed_floor = RST_SPEED_FLOOR;
         speed_ceil  = RST_SPEED_CEIL;
         pid_enable  = 1'b0;
         prev_err    = '0;
         err_sum     = '0;
         held_period = 16'd500;
         mismatches  = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            REG_SETPOINT:    setpoint    = value[FORCE_W-1:0];
            REG_KP:          kp          = value;
            REG_KI:          ki          = value;
            REG_KD:          kd          = value;
            REG_SEP_LIMIT:   sep_limit   = value[LIMIT_W-1:0];
            REG_SPEED_FLOOR: speed_floor = value[SPEED_W-1:0];
            REG_SPEED_CEIL:  speed_ceil  = value[SPEED_W-1:0];
            REG_PID_ENABLE:  pid_enable  = value[0];
            default: ;
         endcase
      endfunction

      function logic signed [31:0] clamp32(longint v);
         if (v > longint'(32'sh7FFFFFFF))
            return 32'sh7FFFFFFF;
         if (v < -longint'(32'sh7FFFFFFF) - 1)
            return 32'sh80000000;
         return v[31:0];
      endfunction

      // Works out the drive for one force sample and advances the loop state.
      function drive_result_type predict_drive(logic signed [FORCE_W-1:0] meas);
         drive_result_type          r;
         logic signed [FORCE_W-1:0] err;
         logic signed [31:0]        drv;
         longint                    mag, acc, speed, lo, q;
         bit                        use_int;
         // The error wraps to 16 bits, so a far-off sample can flip its sign.
         err = setpoint - meas;
         mag = (err < 0) ? -longint'(err) : longint'(err);
         use_int = mag <= longint'(sep_limit);
         if (use_int)
            err_sum = clamp32(longint'(err_sum) + longint'(err));
         acc = longint'(kp) * longint'(err);
         if (use_int)
            acc += longint'(ki) * longint'(err_sum);
         acc += longint'(kd) * (longint'(err) - longint'(prev_err));
         prev_err = err;
         r.direction = acc >= 0;
         // Signed division truncates toward zero, as the controller does.
         drv = clamp32(acc / (longint'(1) <<< GAIN_SHIFT));
         if (pid_enable) begin
            speed = (drv < 0) ? -longint'(drv) : longint'(drv);
            if (speed > longint'(speed_ceil))
               speed = longint'(speed_ceil);
            lo = (speed_floor == 0) ? 1 : longint'(speed_floor);
            if (speed < lo)
               speed = lo;
            q = STEP_CLOCK_HZ / speed;
            held_period = (q > 65535) ? 16'hFFFF : q[15:0];
         end
         r.drive_valid = pid_enable;
         r.half_period = held_period;
         r.drive_value = drv;
         return r;
      endfunction

      function void note_sample(logic [FORCE_W-1:0] meas);
         pending_drives.push_back(predict_drive(meas));
      endfunction

      task report_mismatch(string what);
         $display("%0t ns: mismatch: %s", $time, what);
         mismatches++;
      endtask

      task check_drive(bit dv, bit dir, logic [PERIOD_W-1:0] hp, logic [DRIVE_W-1:0] dval);
         drive_result_type e;
         if (pending_drives.size() == 0) begin
            report_mismatch("result word arrived with no sample outstanding");
            return;
         end
         e = pending_drives.pop_front();
         if (dv !== e.drive_valid)
            report_mismatch($sformatf("drive_valid %b, expected %b", dv, e.drive_valid));
         if (dir !== e.direction)
            report_mismatch($sformatf("direction %b, expected %b", dir, e.direction));
         if (hp !== e.half_period)
            report_mismatch($sformatf("half_period %0d, expected %0d", hp, e.half_period));
         if (dval !== e.drive_value)
            report_mismatch($sformatf("drive_value %0d, expected %0d",
                                      $signed(dval), $signed(e.drive_value)));
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [FORCE_W-1:0]    req_measured_force;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_drive_valid;
   logic                  rsp_direction;
   logic [PERIOD_W-1:0]   rsp_half_period;
   logic [DRIVE_W-1:0]    rsp_drive_value;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   drive_tracker_type tracker;

   // Idling switches for the two sides, and the request for one long receiver hold.
   bit send_gaps    = 1'b1;
   bit rsp_gaps     = 1'b1;
   bit hold_request = 1'b0;
   int hold_cycles  = 0;
   int cycle_count  = 0;

   pid_stepper_rate_control uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_measured_force (req_measured_force),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_drive_valid    (rsp_drive_valid),
      .rsp_direction      (rsp_direction),
      .rsp_half_period    (rsp_half_period),
      .rsp_drive_value    (rsp_drive_value),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Watchdog: a hung handshake or a lost word ends the run here as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[pid_stepper_rate_control] ERROR");
         $finish;
      end
   end

   // Offers one force word and waits until the block takes it. The word is handed
   // to the tracker at the accepting edge, so the prediction sees the registers as
   // they were then. Afterwards the sender sometimes drops valid for a random gap;
   // the gap lengths spread over the whole latency, so the next word lands on every
   // stage of the block's work.
   task automatic send_measurement(input logic [FORCE_W-1:0] meas);
      req_valid          <= 1'b1;
      req_measured_force <= meas;
      do
         @(posedge clock);
      while (!req_ready);
      tracker.note_sample(meas);
      if (send_gaps && $urandom_range(99) < 10) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 60)) @(posedge clock);
      end
   endtask

   // Drops valid and waits until every word sent so far has come back. Every sample
   // yields exactly one result word, so an empty queue means the block is idle.
   task automatic settle();
      req_valid <= 1'b0;
      while (tracker.pending_drives.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      tracker.set_reg(idx, value);
   endtask

   // Writes the whole register file, one register per cycle, in index order.
   task automatic write_regs(input logic [FORCE_W-1:0] sp, input logic [GAIN_W-1:0] p,
                             input logic [GAIN_W-1:0] i, input logic [GAIN_W-1:0] d,
                             input logic [LIMIT_W-1:0] sep, input logic [SPEED_W-1:0] lo,
                             input logic [SPEED_W-1:0] hi, input bit en);
      write_reg(REG_SETPOINT, CSR_DATA_W'(sp));
      write_reg(REG_KP, p);
      write_reg(REG_KI, i);
      write_reg(REG_KD, d);
      write_reg(REG_SEP_LIMIT, CSR_DATA_W'(sep));
      write_reg(REG_SPEED_FLOOR, CSR_DATA_W'(lo));
      write_reg(REG_SPEED_CEIL, CSR_DATA_W'(hi));
      write_reg(REG_PID_ENABLE, CSR_DATA_W'(en));
      csr_we <= 1'b0;
   endtask

   // Random register settings. The minimum speed is sometimes zero and sometimes
   // above the maximum, so both of those clamp corners come up now and then.
   task automatic randomize_regs(input bit en, input int unsigned ki_max);
      write_regs(FORCE_W'($urandom()),
                 GAIN_W'(($urandom() & 32'hFFFFFF) >> $urandom_range(2, 14)),
                 GAIN_W'($urandom_range(0, ki_max)),
                 GAIN_W'(($urandom() & 32'hFFFFFF) >> $urandom_range(2, 14)),
                 LIMIT_W'($urandom_range(0, 32767) >> $urandom_range(0, 14)),
                 SPEED_W'($urandom_range(0, 400)),
                 SPEED_W'($urandom_range(50, 30000)),
                 en);
   endtask

   task automatic send_list(input logic [FORCE_W-1:0] samples[$]);
      foreach (samples[k])
         send_measurement(samples[k]);
      settle();
   endtask

   // Random force words. Most sit around the setpoint, inside or just outside the
   // integration window, which is where a real loop spends its time; the wind-up
   // mode instead keeps the error large and positive so the integral keeps growing.
   // The remainder are full-range noise, which also wraps the error.
   task automatic send_random(input int count, input int noise_pct, input bit wind_up);
      logic [FORCE_W-1:0] meas;
      int                 span;
      repeat (count) begin
         span = int'(tracker.sep_limit) + 40;
         if ($urandom_range(99) < noise_pct)
            meas = FORCE_W'($urandom());
         else if (wind_up)
            meas = FORCE_W'($urandom_range(0, 1500));
         else
            meas = FORCE_W'(int'(tracker.setpoint) + int'($urandom_range(0, 2 * span)) - span);
         send_measurement(meas);
      end
      settle();
   endtask

   // Receiver: checks each accepted result word, then decides ready for the next
   // cycle. A hold request from the stimulus side turns into a long stretch of
   // ready low, counted here, during which the block fills and stalls its input.
   initial begin
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset)
         @(posedge clock);
      forever begin
         if (rsp_valid && rsp_ready)
            tracker.check_drive(rsp_drive_valid, rsp_direction, rsp_half_period,
                                rsp_drive_value);
         if (hold_cycles != 0) begin
            hold_cycles--;
            rsp_ready <= 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_cycles  = RSP_HOLD_LEN;
            rsp_ready   <= 1'b0;
         end else begin
            rsp_ready <= !(rsp_gaps && $urandom_range(99) < 10);
         end
         @(posedge clock);
      end
   end

   initial begin
      tracker = new();
      reset              <= 1'b1;
      req_valid          <= 1'b0;
      req_measured_force <= '0;
      csr_we             <= 1'b0;
      csr_index          <= REG_SETPOINT;
      csr_wdata          <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings with the loop disabled: error at zero, at the separation
      // limit and one past it, the field extremes, and a sample that wraps the
      // error to its most negative value, which never integrates.
      send_list('{16'd400, -16'sd32368, 16'd250, 16'd249, 16'sd32767, -16'sd32768});

      // Same gains with the loop enabled, so the period starts to follow the drive.
      write_regs(RST_SETPOINT, RST_KP, RST_KI, RST_KD, RST_SEP_LIMIT, RST_SPEED_FLOOR,
                 RST_SPEED_CEIL, 1'b1);
      send_list('{16'd400, 16'd390, 16'd600, -16'sd32768});

      // Low extremes: zero gains give zero drive, and a zero minimum speed acts as
      // one, so the period quotient overflows and saturates at its maximum.
      write_regs(-16'sd32768, '0, '0, '0, '0, 16'd0, 16'hFFFF, 1'b1);
      send_list('{-16'sd32768, 16'd0});

      // High extremes: full gains, widest window, and crossed speed limits where
      // the minimum speed has to win.
      write_regs(16'sd32767, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 15'h7FFF, 16'd5000,
                 16'd100, 1'b1);
      send_list('{-16'sd32768, 16'sd32767, 16'd0, -16'sd1});

      // Random settings with the loop enabled. The receiver holds off for a long
      // stretch at the start while the sender keeps offering words.
      randomize_regs(1'b1, 32'hFFFF);
      hold_request = 1'b1;
      send_random(110, 15, 1'b0);

      // Loop disabled, and neither side idles for this whole stretch.
      send_gaps = 1'b0;
      rsp_gaps  = 1'b0;
      randomize_regs(1'b0, 32'hFFFF);
      send_random(70, 15, 1'b0);
      send_gaps = 1'b1;
      rsp_gaps  = 1'b1;

      // Integral wind-up: with the widest window and full integral gain, a long run
      // of large positive errors drives the output into positive saturation.
      write_regs(16'sd32767, GAIN_W'($urandom()), 24'hFFFFFF, GAIN_W'($urandom()), 15'h7FFF,
                 SPEED_W'($urandom_range(0, 400)), SPEED_W'($urandom_range(50, 30000)), 1'b1);
      send_random(330, 5, 1'b1);

      // The integral is now large; small integral gains keep the drive varied.
      randomize_regs(1'b1, 200);
      send_random(50, 15, 1'b0);

      // Everything has come back; give a late spurious word time to show up.
      repeat (60) @(posedge clock);
      if (tracker.mismatches == 0)
         $display("[pid_stepper_rate_control] OK");
      else
         $display("[pid_stepper_rate_control] ERROR");
      $finish;
   end

endmodule

// ----- pid_stepper_rate_control.f -----
hw/rtl/pscr_pkg.sv
hw/rtl/pid_stepper_rate_control.sv
sim/tb.sv
